FILE: rtl/pgrs_pkg.sv
// Shared types and constants for the polar grid restriction scatter block.
`default_nettype none
package pgrs_pkg;

   // Operation codes carried by the request opcode field.
   localparam logic [1:0] OP_CLEAR   = 2'd0;
   localparam logic [1:0] OP_SCATTER = 2'd1;
   localparam logic [1:0] OP_READ    = 2'd2;

   // Result status codes.
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_RANGE = 2'd1;
   localparam logic [1:0] STAT_ZERO  = 2'd2;

   // Configuration register indexes and reset values.
   localparam logic CSR_RADII  = 1'b0;
   localparam logic CSR_ANGLES = 1'b1;
   localparam logic [6:0] RADII_RESET  = 7'd64;
   localparam logic [7:0] ANGLES_RESET = 8'd128;

   // Quotient bits produced by the bit-serial divider.
   localparam int DIV_STEPS = 32;

   // Limits of the 40-bit read result.
   localparam logic signed [63:0] READ_MAX = 64'sd549755813887;
   localparam logic signed [63:0] READ_MIN = -64'sd549755813888;

   typedef enum logic [3:0] {
      S_CLEAR_INIT,
      S_CLEAR_OP,
      S_IDLE,
      S_DECODE,
      S_WEIGHT,
      S_MUL,
      S_DIV,
      S_RMW_RD,
      S_RMW_WR,
      S_READ,
      S_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic load_weight;
      logic load_prod;
      logic div_step;
      logic mem_rd_upd;
      logic mem_wr_upd;
      logic mem_rd_sum;
      logic clr_wr;
      logic load_rsp;
      logic rsel;
      logic asel;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] opcode;
      logic [1:0] code;
      logic       rodd;
      logic       aodd;
   } stat_type;

endpackage
`default_nettype wire

FILE: rtl/polar_grid_restriction_scatter.sv
// Top level of the polar grid restriction scatter block.
//
// Channel  Direction  Transfer when          Carries
// req_     in         req_valid & req_ready  opcode, fine node, spacings, coarse index
// rsp_     out        rsp_valid & rsp_ready  read_sum, status
// csr_     in         csr_valid & csr_ready  register index, write data
//
// One item at a time. A scatter makes 1, 2 or 4 coarse updates, each run through
// the 32-step serial divider. A clear writes one store row per cycle.
// After reset the store is swept to zero with req_ready low.
// The next item is taken while the previous result waits in the output register;
// it finishes only once that result has been taken.
`default_nettype none
module polar_grid_restriction_scatter #(
   parameter int MAX_COARSE_RADII = 64,
   parameter int MAX_COARSE_ANGLES = 128,
   parameter int SUM_WIDTH = 40
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic               csr_index,
   input  wire logic [7:0]         csr_wdata,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_opcode,
   input  wire logic [6:0]         req_fine_radial,
   input  wire logic [7:0]         req_fine_angle,
   input  wire logic signed [31:0] req_fine_value,
   input  wire logic [15:0]        req_gap_radial_inner,
   input  wire logic [15:0]        req_gap_radial_outer,
   input  wire logic [15:0]        req_gap_angle_lower,
   input  wire logic [15:0]        req_gap_angle_upper,
   input  wire logic [5:0]         req_coarse_radial,
   input  wire logic [6:0]         req_coarse_angle,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [39:0]      rsp_read_sum,
   output logic [1:0]              rsp_status
);

   localparam int Depth = MAX_COARSE_RADII * MAX_COARSE_ANGLES;
   localparam int AddrWidth = $clog2(Depth);

   pgrs_pkg::cmd_type cmd;
   pgrs_pkg::stat_type stat;
   logic [AddrWidth-1:0] clr_addr;

   // Registers are written whenever a transfer arrives.
   assign csr_ready = 1'b1;

   pgrs_ctrl #(
      .DEPTH(Depth),
      .ADDR_WIDTH(AddrWidth)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .stat(stat),
      .cmd(cmd),
      .clr_addr(clr_addr)
   );

   pgrs_dp #(
      .MAX_COARSE_RADII(MAX_COARSE_RADII),
      .MAX_COARSE_ANGLES(MAX_COARSE_ANGLES),
      .SUM_WIDTH(SUM_WIDTH),
      .DEPTH(Depth),
      .ADDR_WIDTH(AddrWidth)
   ) u_dp (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_opcode(req_opcode),
      .req_fine_radial(req_fine_radial),
      .req_fine_angle(req_fine_angle),
      .req_fine_value(req_fine_value),
      .req_gap_radial_inner(req_gap_radial_inner),
      .req_gap_radial_outer(req_gap_radial_outer),
      .req_gap_angle_lower(req_gap_angle_lower),
      .req_gap_angle_upper(req_gap_angle_upper),
      .req_coarse_radial(req_coarse_radial),
      .req_coarse_angle(req_coarse_angle),
      .cmd(cmd),
      .clr_addr(clr_addr),
      .stat(stat),
      .rsp_read_sum(rsp_read_sum),
      .rsp_status(rsp_status)
   );

endmodule
`default_nettype wire

FILE: rtl/pgrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pgrs_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 8192
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule
`default_nettype wire

FILE: rtl/pgrs_ctrl.sv
// Controller state machine: sequences clears, scatter updates and reads.
`default_nettype none
module pgrs_ctrl #(
   parameter int DEPTH = 8192,
   parameter int ADDR_WIDTH = 13
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire pgrs_pkg::stat_type    stat,
   output pgrs_pkg::cmd_type          cmd,
   output logic [ADDR_WIDTH-1:0]      clr_addr
);

   pgrs_pkg::state_type state_ff, state_in;
   logic [ADDR_WIDTH-1:0] clr_cnt_ff, clr_cnt_in;
   logic [4:0] div_cnt_ff, div_cnt_in;
   logic [1:0] upd_ff, upd_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic clr_last, div_last, upd_last;
   logic req_xfer;
   logic rsp_free;

   assign clr_last = (clr_cnt_ff == ADDR_WIDTH'(DEPTH - 1));
   assign div_last = (div_cnt_ff == 5'(pgrs_pkg::DIV_STEPS - 1));
   assign upd_last = (upd_ff == {stat.aodd & stat.rodd, stat.aodd | stat.rodd});
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == pgrs_pkg::S_IDLE);
   assign req_xfer = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign clr_addr = clr_cnt_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pgrs_pkg::S_CLEAR_INIT: begin
            if (clr_last) state_in = pgrs_pkg::S_IDLE;
         end
         pgrs_pkg::S_CLEAR_OP: begin
            if (clr_last) state_in = pgrs_pkg::S_DONE;
         end
         pgrs_pkg::S_IDLE: begin
            if (req_xfer) state_in = pgrs_pkg::S_DECODE;
         end
         pgrs_pkg::S_DECODE: begin
            priority if (stat.code != pgrs_pkg::STAT_OK) begin
               state_in = pgrs_pkg::S_DONE;
            end else if (stat.opcode == pgrs_pkg::OP_CLEAR) begin
               state_in = pgrs_pkg::S_CLEAR_OP;
            end else if (stat.opcode == pgrs_pkg::OP_SCATTER) begin
               state_in = pgrs_pkg::S_WEIGHT;
            end else if (stat.opcode == pgrs_pkg::OP_READ) begin
               state_in = pgrs_pkg::S_READ;
            end else begin
               state_in = pgrs_pkg::S_DONE;
            end
         end
         pgrs_pkg::S_WEIGHT: state_in = pgrs_pkg::S_MUL;
         pgrs_pkg::S_MUL:    state_in = pgrs_pkg::S_DIV;
         pgrs_pkg::S_DIV: begin
            if (div_last) state_in = pgrs_pkg::S_RMW_RD;
         end
         pgrs_pkg::S_RMW_RD: state_in = pgrs_pkg::S_RMW_WR;
         pgrs_pkg::S_RMW_WR: begin
            state_in = upd_last ? pgrs_pkg::S_DONE : pgrs_pkg::S_WEIGHT;
         end
         pgrs_pkg::S_READ: state_in = pgrs_pkg::S_DONE;
         pgrs_pkg::S_DONE: begin
            // Wait here while the previous result still sits in the output register.
            if (rsp_free) state_in = pgrs_pkg::S_IDLE;
         end
         default: state_in = pgrs_pkg::S_IDLE;
      endcase
   end

   // Counters and response valid.
   always_comb begin
      clr_cnt_in = clr_cnt_ff;
      div_cnt_in = div_cnt_ff;
      upd_in = upd_ff;
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == pgrs_pkg::S_CLEAR_INIT || state_ff == pgrs_pkg::S_CLEAR_OP) begin
         clr_cnt_in = clr_last ? '0 : clr_cnt_ff + 1'b1;
      end
      if (state_ff == pgrs_pkg::S_DIV) begin
         div_cnt_in = div_cnt_ff + 1'b1;
      end
      if (state_ff == pgrs_pkg::S_DECODE) begin
         upd_in = '0;
      end else if (state_ff == pgrs_pkg::S_RMW_WR) begin
         upd_in = upd_ff + 1'b1;
      end
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (state_ff == pgrs_pkg::S_DONE && rsp_free) rsp_valid_in = 1'b1;
   end

   // Datapath commands.
   always_comb begin
      cmd = '0;
      cmd.rsel = stat.rodd & upd_ff[0];
      cmd.asel = stat.aodd & (stat.rodd ? upd_ff[1] : upd_ff[0]);
      cmd.load_req = req_xfer;
      unique case (state_ff)
         pgrs_pkg::S_CLEAR_INIT, pgrs_pkg::S_CLEAR_OP: cmd.clr_wr = 1'b1;
         pgrs_pkg::S_WEIGHT: cmd.load_weight = 1'b1;
         pgrs_pkg::S_MUL:    cmd.load_prod = 1'b1;
         pgrs_pkg::S_DIV:    cmd.div_step = 1'b1;
         pgrs_pkg::S_RMW_RD: cmd.mem_rd_upd = 1'b1;
         pgrs_pkg::S_RMW_WR: cmd.mem_wr_upd = 1'b1;
         pgrs_pkg::S_READ:   cmd.mem_rd_sum = 1'b1;
         pgrs_pkg::S_DONE:   cmd.load_rsp = rsp_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pgrs_pkg::S_CLEAR_INIT;
         clr_cnt_ff <= '0;
         div_cnt_ff <= '0;
         upd_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         div_cnt_ff <= div_cnt_in;
         upd_ff <= upd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/pgrs_dp.sv
// Datapath: request registers, weight multiply, serial divider, store and result.
`default_nettype none
module pgrs_dp #(
   parameter int MAX_COARSE_RADII = 64,
   parameter int MAX_COARSE_ANGLES = 128,
   parameter int SUM_WIDTH = 40,
   parameter int DEPTH = 8192,
   parameter int ADDR_WIDTH = 13
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   input  wire logic                  csr_index,
   input  wire logic [7:0]            csr_wdata,
   input  wire logic [1:0]            req_opcode,
   input  wire logic [6:0]            req_fine_radial,
   input  wire logic [7:0]            req_fine_angle,
   input  wire logic signed [31:0]    req_fine_value,
   input  wire logic [15:0]           req_gap_radial_inner,
   input  wire logic [15:0]           req_gap_radial_outer,
   input  wire logic [15:0]           req_gap_angle_lower,
   input  wire logic [15:0]           req_gap_angle_upper,
   input  wire logic [5:0]            req_coarse_radial,
   input  wire logic [6:0]            req_coarse_angle,
   input  wire pgrs_pkg::cmd_type     cmd,
   input  wire logic [ADDR_WIDTH-1:0] clr_addr,
   output pgrs_pkg::stat_type         stat,
   output logic signed [39:0]         rsp_read_sum,
   output logic [1:0]                 rsp_status
);

   // Configuration registers.
   logic [6:0] radii_ff;
   logic [7:0] angles_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radii_ff <= pgrs_pkg::RADII_RESET;
         angles_ff <= pgrs_pkg::ANGLES_RESET;
      end else if (csr_valid) begin
         if (csr_index == pgrs_pkg::CSR_RADII) radii_ff <= csr_wdata[6:0];
         else angles_ff <= csr_wdata;
      end
   end

   // Request registers, loaded on an accepted transfer.
   logic [1:0] op_ff;
   logic [6:0] fr_ff;
   logic [7:0] fa_ff;
   logic [31:0] val_ff;
   logic [15:0] h1_ff, h2_ff, k1_ff, k2_ff;
   logic [5:0] cr_ff;
   logic [6:0] ca_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff <= req_opcode;
         fr_ff <= req_fine_radial;
         fa_ff <= req_fine_angle;
         val_ff <= req_fine_value;
         h1_ff <= req_gap_radial_inner;
         h2_ff <= req_gap_radial_outer;
         k1_ff <= req_gap_angle_lower;
         k2_ff <= req_gap_angle_upper;
         cr_ff <= req_coarse_radial;
         ca_ff <= req_coarse_angle;
      end
   end

   // Index decode and checks.
   logic [31:0] eff_r, eff_a;
   logic rodd, aodd;
   logic [5:0] base_r;
   logic [6:0] base_a;
   logic [6:0] rtop;
   logic [7:0] a_inc, a_plus;
   logic [16:0] hs, ks;
   logic scat_range, scat_zero, read_range;

   assign eff_r = (32'(radii_ff) < 32'(MAX_COARSE_RADII)) ? 32'(radii_ff)
                                                        : 32'(MAX_COARSE_RADII);
   assign eff_a = (32'(angles_ff) < 32'(MAX_COARSE_ANGLES)) ? 32'(angles_ff)
                                                          : 32'(MAX_COARSE_ANGLES);
   assign rodd = fr_ff[0];
   assign aodd = fa_ff[0];
   assign base_r = fr_ff[6:1];
   assign base_a = fa_ff[7:1];
   assign rtop = {1'b0, base_r} + {6'd0, rodd};
   assign a_inc = {1'b0, base_a} + 8'd1;
   assign a_plus = (32'(a_inc) >= eff_a) ? 8'd0 : a_inc;
   assign hs = {1'b0, h1_ff} + {1'b0, h2_ff};
   assign ks = {1'b0, k1_ff} + {1'b0, k2_ff};
   assign scat_range = (32'(rtop) >= eff_r) || (32'(base_a) >= eff_a);
   assign scat_zero = (rodd && hs == '0) || (aodd && ks == '0);
   assign read_range = (32'(cr_ff) >= eff_r) || (32'(ca_ff) >= eff_a);

   always_comb begin
      stat.opcode = op_ff;
      stat.rodd = rodd;
      stat.aodd = aodd;
      stat.code = pgrs_pkg::STAT_OK;
      if (op_ff == pgrs_pkg::OP_SCATTER) begin
         if (scat_range) stat.code = pgrs_pkg::STAT_RANGE;
         else if (scat_zero) stat.code = pgrs_pkg::STAT_ZERO;
      end else if (op_ff == pgrs_pkg::OP_READ) begin
         if (read_range) stat.code = pgrs_pkg::STAT_RANGE;
      end
   end

   // Weight and divisor of the current share.
   logic [15:0] rf, af;
   logic [16:0] rd, ad;
   logic [31:0] weight_ff;
   logic [33:0] divisor_ff;

   assign rf = rodd ? (cmd.rsel ? h2_ff : h1_ff) : 16'd1;
   assign af = aodd ? (cmd.asel ? k2_ff : k1_ff) : 16'd1;
   assign rd = rodd ? hs : 17'd1;
   assign ad = aodd ? ks : 17'd1;

   always_ff @(posedge clock) begin
      if (cmd.load_weight) begin
         weight_ff <= rf * af;
         divisor_ff <= rd * ad;
      end
   end

   // Product of weight and magnitude, then restoring division one bit a cycle.
   logic neg;
   logic [31:0] mag;
   logic [63:0] prod;
   logic [33:0] rem_ff;
   logic [31:0] quo_ff;
   logic [34:0] trial, diff;
   logic ge;

   assign neg = val_ff[31];
   assign mag = neg ? (32'd0 - val_ff) : val_ff;
   assign prod = weight_ff * mag;
   assign trial = {rem_ff, quo_ff[31]};
   assign diff = trial - {1'b0, divisor_ff};
   assign ge = (trial >= {1'b0, divisor_ff});

   always_ff @(posedge clock) begin
      if (cmd.load_prod) begin
         rem_ff <= {2'b00, prod[63:32]};
         quo_ff <= prod[31:0];
      end else if (cmd.div_step) begin
         rem_ff <= ge ? diff[33:0] : trial[33:0];
         quo_ff <= {quo_ff[30:0], ge};
      end
   end

   // Store addresses.
   logic [6:0] upd_r;
   logic [7:0] upd_a;
   logic [ADDR_WIDTH-1:0] upd_addr, read_addr;

   assign upd_r = {1'b0, base_r} + {6'd0, cmd.rsel};
   assign upd_a = cmd.asel ? a_plus : {1'b0, base_a};
   assign upd_addr = ADDR_WIDTH'(32'(upd_r) * 32'(MAX_COARSE_ANGLES) + 32'(upd_a));
   assign read_addr = ADDR_WIDTH'(32'(cr_ff) * 32'(MAX_COARSE_ANGLES) + 32'(ca_ff));

   // Saturating accumulate of the signed share.
   logic signed [32:0] delta;
   logic [SUM_WIDTH-1:0] ram_rdata, acc_sum;
   logic [SUM_WIDTH:0] acc_ext;

   assign delta = neg ? (33'sd0 - $signed({1'b0, quo_ff})) : $signed({1'b0, quo_ff});
   assign acc_ext = {ram_rdata[SUM_WIDTH-1], ram_rdata}
                  + {{(SUM_WIDTH - 32){delta[32]}}, delta};

   always_comb begin
      if (acc_ext[SUM_WIDTH] != acc_ext[SUM_WIDTH-1]) begin
         acc_sum = acc_ext[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                      : {1'b0, {(SUM_WIDTH-1){1'b1}}};
      end else begin
         acc_sum = acc_ext[SUM_WIDTH-1:0];
      end
   end

   // Coarse sum store.
   logic ram_we, ram_re;
   logic [ADDR_WIDTH-1:0] ram_waddr, ram_raddr;
   logic [SUM_WIDTH-1:0] ram_wdata;

   assign ram_we = cmd.clr_wr | cmd.mem_wr_upd;
   assign ram_waddr = cmd.clr_wr ? clr_addr : upd_addr;
   assign ram_wdata = cmd.clr_wr ? '0 : acc_sum;
   assign ram_re = cmd.mem_rd_upd | cmd.mem_rd_sum;
   assign ram_raddr = cmd.mem_rd_sum ? read_addr : upd_addr;

   pgrs_ram #(
      .WIDTH(SUM_WIDTH),
      .DEPTH(DEPTH)
   ) u_store (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re(ram_re),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   // Result register, clamped to the 40-bit output range.
   logic signed [63:0] sum_wide;
   logic signed [39:0] sum_clamp;
   logic signed [39:0] rsp_sum_ff;
   logic [1:0] rsp_status_ff;

   assign sum_wide = 64'($signed(ram_rdata));

   always_comb begin
      if (sum_wide > pgrs_pkg::READ_MAX) sum_clamp = pgrs_pkg::READ_MAX[39:0];
      else if (sum_wide < pgrs_pkg::READ_MIN) sum_clamp = pgrs_pkg::READ_MIN[39:0];
      else sum_clamp = sum_wide[39:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff <= stat.code;
         rsp_sum_ff <= (op_ff == pgrs_pkg::OP_READ && stat.code == pgrs_pkg::STAT_OK)
                       ? sum_clamp : '0;
      end
   end

   assign rsp_read_sum = rsp_sum_ff;
   assign rsp_status = rsp_status_ff;

endmodule
`default_nettype wire

FILE: rtl/pgrs_checker.sv
// Port-level checks for the polar grid restriction scatter block, with its bind.
`default_nettype none
module pgrs_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic signed [39:0] rsp_read_sum,
   input wire logic [1:0]         rsp_status
);

   // A held result keeps its payload until the transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_sum) && $stable(rsp_status))
      else $error("result changed while stalled");

   // A failed item never carries a sum.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != pgrs_pkg::STAT_OK |-> rsp_read_sum == '0)
      else $error("nonzero sum with error status");

   // One item at a time: the block is busy right after a transfer in.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while busy");

   // Reset starts the clearing sweep with no result pending.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("block not idle and clearing after reset");

endmodule

bind polar_grid_restriction_scatter pgrs_checker u_pgrs_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_read_sum(rsp_read_sum),
   .rsp_status(rsp_status)
);
`default_nettype wire
